@@ sv/first_fit_heap_allocator_macros.svh @@
// Assertion macros for the first-fit heap allocator.
// Used by first_fit_heap_allocator.sv; expects aclk and aresetn in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define FFHA_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("ffha: invariant violated");

// A condition that must hold in the cycle after a trigger.
`define FFHA_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("ffha: sequence violated");

`endif

@@ sv/ffha_pkg.sv @@
// Types and constants shared by the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

    localparam int PTR_W   = 16;   // word pointer, covers a header step past the heap end
    localparam int GRANT_W = 12;

    localparam logic [15:0] SIZE_MASK = 16'hFFFE;
    localparam logic [15:0] USED_BIT  = 16'h0001;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [15:0]        request_bytes;
        logic [GRANT_W-1:0] block_address;
    } ffha_in_t;

    typedef struct packed {
        logic               ok;
        logic [GRANT_W-1:0] granted_address;
        logic [15:0]        used_bytes;
        logic [15:0]        free_bytes;
    } ffha_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CUR_RD,
        ST_CUR_CHK,
        ST_WALK_RD,
        ST_WALK_EVAL,
        ST_TAKE,
        ST_SKIP_RD,
        ST_SKIP_EVAL,
        ST_FINISH,
        ST_REL_RD,
        ST_REL_EVAL,
        ST_RESP
    } ffha_state_t;

endpackage

@@ sv/first_fit_heap_allocator.sv @@
// First-fit heap allocator with free-block merging, top level.
// Depends on ffha_pkg and first_fit_heap_allocator_macros.svh.
//
//   channel | ports                      | word
//   input   | s_valid, s_ready, s_data   | ffha_in_t  (alloc or release command)
//   result  | m_valid, m_ready, m_data   | ffha_out_t (status, granted address and byte totals)
//
// After reset a clearing pass writes all HEAP_WORDS words of the heap memory, one word a cycle.
// A rejected word goes straight to ST_RESP, which raises m_valid; a release reads its header first.
// An alloc reads the header at the free cursor; if it fits, ST_TAKE splits it or, on an exact fit,
// skips the further used blocks, else a merge walk reads each header from word 0 and may fail.
// Each header visited is one read of the heap memory, which has one write and one read port.
// A result waits in the output register while m_ready is low; s_ready rises once it is loaded.
`include "first_fit_heap_allocator_macros.svh"

module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_WORDS = 4096
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ffha_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output ffha_out_t m_data
);

    localparam int AW = $clog2(HEAP_WORDS);
    localparam logic [PTR_W-1:0] DEPTH_P  = PTR_W'(HEAP_WORDS);
    localparam logic [AW-1:0]    LAST_IDX = AW'(HEAP_WORDS - 1);
    localparam logic [15:0]      HEAP_LEN = 16'(2 * (HEAP_WORDS - 1));

    ffha_state_t state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [15:0]        need_reg, need_next;
    logic [PTR_W-1:0]   rel_reg, rel_next;
    logic [PTR_W-1:0]   cursor_reg, cursor_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [PTR_W-1:0]   start_reg, start_next;
    logic [15:0]        run_reg, run_next;
    logic [PTR_W-1:0]   p_reg, p_next;
    logic [15:0]        old_reg, old_next;
    logic [15:0]        used_reg, used_next;
    logic               ok_reg, ok_next;
    logic [GRANT_W-1:0] grant_reg, grant_next;
    logic               m_valid_reg, m_valid_next;
    ffha_out_t          m_data_reg;

    // Heap memory, one write and one registered read port.
    logic [15:0]      mem [HEAP_WORDS];
    logic             mem_we;
    logic             mem_wr_en;
    logic [PTR_W-1:0] mem_waddr;
    logic [15:0]      mem_wdata;
    logic [PTR_W-1:0] mem_raddr;
    logic [15:0]      rdata_reg;
    logic             rd_ok_reg;

    // Shared pointer adder and decoded header.
    logic [PTR_W-1:0] add_a;
    logic [14:0]      add_b;
    logic [PTR_W-1:0] ptr_sum;
    logic [15:0]      hdr;
    logic [14:0]      hdr_st;
    logic [16:0]      adj;
    logic [15:0]      rem;
    logic [PTR_W-1:0] p_plus1;
    logic             out_load;

    assign hdr     = rd_ok_reg ? rdata_reg : 16'd0;
    assign hdr_st  = hdr[15:1];
    assign ptr_sum = add_a + PTR_W'(add_b);
    assign adj     = ({1'b0, s_data.request_bytes} + 17'd3) & {1'b1, SIZE_MASK};
    assign rem     = old_reg - need_reg;
    assign p_plus1 = p_reg + PTR_W'(1);

    assign mem_wr_en = mem_we && (mem_waddr < DEPTH_P);

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr[AW-1:0]];
        rd_ok_reg <= (mem_raddr < DEPTH_P);
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        need_next    = need_reg;
        rel_next     = rel_reg;
        cursor_next  = cursor_reg;
        ptr_next     = ptr_reg;
        start_next   = start_reg;
        run_next     = run_reg;
        p_next       = p_reg;
        old_next     = old_reg;
        used_next    = used_reg;
        ok_next      = ok_reg;
        grant_next   = grant_reg;
        mem_we       = 1'b0;
        mem_waddr    = ptr_reg;
        mem_wdata    = 16'd0;
        mem_raddr    = ptr_reg;
        add_a        = ptr_reg;
        add_b        = hdr_st;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = PTR_W'(clr_reg);
                mem_wdata = (clr_reg == '0) ? HEAP_LEN : 16'd0;
                if (clr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    ok_next    = 1'b0;
                    grant_next = '0;
                    if (s_data.cmd == CMD_ALLOC) begin
                        need_next = adj[15:0];
                        if (s_data.request_bytes == 16'd0 || adj[16]) begin
                            state_next = ST_RESP;
                        end else begin
                            state_next = ST_CUR_RD;
                        end
                    end else begin
                        rel_next = PTR_W'(s_data.block_address) - PTR_W'(1);
                        if (s_data.block_address != '0 &&
                            PTR_W'(s_data.block_address) < DEPTH_P) begin
                            state_next = ST_REL_RD;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end
                end
            end
            ST_CUR_RD: begin
                mem_raddr  = cursor_reg;
                state_next = ST_CUR_CHK;
            end
            ST_CUR_CHK: begin
                if (need_reg > hdr) begin
                    ptr_next   = '0;
                    start_next = '0;
                    run_next   = 16'd0;
                    state_next = ST_WALK_RD;
                end else begin
                    p_next     = cursor_reg;
                    old_next   = hdr;
                    state_next = ST_TAKE;
                end
            end
            ST_WALK_RD: begin
                mem_raddr  = ptr_reg;
                state_next = ST_WALK_EVAL;
            end
            ST_WALK_EVAL: begin
                // A used or terminating header closes the current free run.
                if (hdr_st == '0 || hdr[0]) begin
                    if (hdr_st == '0) begin
                        state_next = ST_RESP;
                    end else begin
                        ptr_next   = ptr_sum;
                        start_next = ptr_sum;
                        run_next   = 16'd0;
                        state_next = ST_WALK_RD;
                    end
                    if (run_reg != 16'd0) begin
                        mem_we    = 1'b1;
                        mem_waddr = start_reg;
                        mem_wdata = run_reg;
                        if (run_reg >= need_reg) begin
                            p_next     = start_reg;
                            old_next   = run_reg;
                            state_next = ST_TAKE;
                        end
                    end
                end else begin
                    run_next   = run_reg + hdr;
                    ptr_next   = ptr_sum;
                    state_next = ST_WALK_RD;
                end
            end
            ST_TAKE: begin
                add_a    = p_reg;
                add_b    = need_reg[15:1];
                ptr_next = ptr_sum;
                if (rem != 16'd0) begin
                    mem_we     = 1'b1;
                    mem_waddr  = ptr_sum;
                    mem_wdata  = rem;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SKIP_RD;
                end
            end
            ST_SKIP_RD: begin
                mem_raddr  = ptr_reg;
                state_next = ST_SKIP_EVAL;
            end
            ST_SKIP_EVAL: begin
                if (!hdr[0] || hdr_st == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    ptr_next   = ptr_sum;
                    state_next = ST_SKIP_RD;
                end
            end
            ST_FINISH: begin
                mem_we      = 1'b1;
                mem_waddr   = p_reg;
                mem_wdata   = need_reg | USED_BIT;
                cursor_next = ptr_reg;
                if (!old_reg[0]) begin
                    used_next = used_reg + need_reg;
                end
                ok_next    = 1'b1;
                grant_next = p_plus1[GRANT_W-1:0];
                state_next = ST_RESP;
            end
            ST_REL_RD: begin
                mem_raddr  = rel_reg;
                state_next = ST_REL_EVAL;
            end
            ST_REL_EVAL: begin
                if (hdr[0]) begin
                    mem_we    = 1'b1;
                    mem_waddr = rel_reg;
                    mem_wdata = hdr & SIZE_MASK;
                    used_next = used_reg - (hdr & SIZE_MASK);
                end
                ok_next    = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            cursor_reg  <= '0;
            used_reg    <= 16'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cursor_reg  <= cursor_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        need_reg  <= need_next;
        rel_reg   <= rel_next;
        ptr_reg   <= ptr_next;
        start_reg <= start_next;
        run_reg   <= run_next;
        p_reg     <= p_next;
        old_reg   <= old_next;
        ok_reg    <= ok_next;
        grant_reg <= grant_next;
        if (out_load) begin
            m_data_reg.ok              <= ok_reg;
            m_data_reg.granted_address <= grant_reg;
            m_data_reg.used_bytes      <= used_reg;
            m_data_reg.free_bytes      <= HEAP_LEN - used_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `FFHA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `FFHA_ASSERT_ALWAYS(a_totals_add_up, !m_valid || 16'(m_data.used_bytes + m_data.free_bytes) == HEAP_LEN)
    `FFHA_ASSERT_ALWAYS(a_grant_needs_ok, !m_valid || m_data.ok || m_data.granted_address == '0)
    `FFHA_ASSERT_ALWAYS(a_no_write_idle, state_reg != ST_IDLE || !mem_we)

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for first_fit_heap_allocator: a shadow heap predicts every reply word.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL.
module testbench;
    import ffha_pkg::*;

    localparam int HEAP_WORDS   = 4096;
    localparam int RANDOM_ITEMS = 600;
    localparam int QUIET_ITEMS  = 100;
    localparam int STALL_LIMIT  = 60000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [15:0] HEAP_LEN = 16'(2 * (HEAP_WORDS - 1));

    // Shadow copy of the heap memory, the free cursor and the used total, plus the
    // queue of reply words that the block still owes.
    class heap_shadow;
        bit [15:0]   heap_mem [HEAP_WORDS];
        int unsigned cursor;
        bit [15:0]   used_sum;
        ffha_out_t   owed_replies [$];
        int          live [$];
        int          failures;

        function new();
            foreach (heap_mem[i]) heap_mem[i] = 16'h0;
            heap_mem[0] = HEAP_LEN;
            cursor      = 0;
            used_sum    = 16'h0;
            failures    = 0;
        endfunction

        function bit [15:0] fetch_word(input int unsigned i);
            return (i < HEAP_WORDS) ? heap_mem[i] : 16'h0;
        endfunction

        function void store_word(input int unsigned i, input bit [15:0] v);
            if (i < HEAP_WORDS) heap_mem[i] = v;
        endfunction

        // Walks the header chain from word 0, folding each run of free blocks into one
        // header, and stops at the first run that holds the request.
        function bit coalesce_find(input bit [15:0] need, output int unsigned found);
            int unsigned b;
            int unsigned start;
            bit [15:0]   run;
            bit [15:0]   h;
            b     = 0;
            start = 0;
            run   = 16'h0;
            found = 0;
            forever begin
                h = fetch_word(b);
                if ((h >> 1) == 0) break;
                if (h[0]) begin
                    if (run != 0) begin
                        store_word(start, run);
                        if (run >= need) begin
                            found = start;
                            return 1'b1;
                        end
                        run = 16'h0;
                    end
                    b += h >> 1;
                    start = b;
                end else begin
                    run += h;
                    b += h >> 1;
                end
            end
            if (run != 0) begin
                store_word(start, run);
                if (run >= need) begin
                    found = start;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_command(input ffha_in_t w);
            ffha_out_t   r;
            bit [16:0]   adj;
            bit [15:0]   need;
            bit [15:0]   old;
            bit [15:0]   rem;
            bit [15:0]   h;
            int unsigned p;
            int unsigned nf;
            bit          have;
            int          hits [$];
            r = '0;
            if (w.cmd == CMD_ALLOC) begin
                adj = ({1'b0, w.request_bytes} + 17'd3) & 17'h1FFFE;
                if (w.request_bytes != 0 && !adj[16]) begin
                    need = adj[15:0];
                    p    = cursor;
                    have = 1'b1;
                    if (need > fetch_word(p)) have = coalesce_find(need, p);
                    if (have) begin
                        old = fetch_word(p);
                        rem = old - need;
                        nf  = p + (need >> 1);
                        if (rem != 0) begin
                            store_word(nf, rem);
                        end else begin
                            // Exact fit: move the cursor past the used blocks that follow.
                            h = fetch_word(nf);
                            while (h[0] && (h >> 1) != 0) begin
                                nf += h >> 1;
                                h = fetch_word(nf);
                            end
                        end
                        cursor = nf;
                        store_word(p, need | USED_BIT);
                        if (!old[0]) used_sum += need;
                        r.ok              = 1'b1;
                        r.granted_address = GRANT_W'(p + 1);
                        hits = live.find_first_index(x) with (x == int'(r.granted_address));
                        if (hits.size() == 0) live.push_back(int'(r.granted_address));
                    end
                end
            end else if (w.block_address != 0 && w.block_address < HEAP_WORDS) begin
                h = heap_mem[w.block_address - 1];
                if (h[0]) begin
                    heap_mem[w.block_address - 1] = h & SIZE_MASK;
                    used_sum -= h & SIZE_MASK;
                end
                r.ok = 1'b1;
                hits = live.find_first_index(x) with (x == int'(w.block_address));
                if (hits.size() != 0) live.delete(hits[0]);
            end
            r.used_bytes = used_sum;
            r.free_bytes = HEAP_LEN - used_sum;
            owed_replies.push_back(r);
        endfunction

        function void note_failure(input string msg);
            failures++;
            if (failures <= 10) $display("%s", msg);
        endfunction

        function void check_reply(input ffha_out_t got);
            ffha_out_t want;
            if (owed_replies.size() == 0) begin
                note_failure($sformatf("unexpected reply: ok=%0d addr=%0d used=%0d free=%0d",
                    got.ok, got.granted_address, got.used_bytes, got.free_bytes));
                return;
            end
            want = owed_replies.pop_front();
            if (got.ok !== want.ok || got.granted_address !== want.granted_address ||
                    got.used_bytes !== want.used_bytes || got.free_bytes !== want.free_bytes)
                note_failure($sformatf(
                    "reply mismatch: expected ok=%0d addr=%0d used=%0d free=%0d, got ok=%0d addr=%0d used=%0d free=%0d",
                    want.ok, want.granted_address, want.used_bytes, want.free_bytes,
                    got.ok, got.granted_address, got.used_bytes, got.free_bytes));
        endfunction

        function int pending();
            return owed_replies.size();
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    ffha_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    ffha_out_t m_data;

    heap_shadow sb = new();
    int         idle_pct = 20;
    bit         quiet = 1'b0;
    int         stuck_cycles = 0;

    first_fit_heap_allocator #(.HEAP_WORDS(HEAP_WORDS)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic ffha_in_t alloc_word(input logic [15:0] bytes);
        ffha_in_t w;
        w.cmd           = CMD_ALLOC;
        w.request_bytes = bytes;
        w.block_address = GRANT_W'($urandom);
        return w;
    endfunction

    function automatic ffha_in_t free_word(input logic [GRANT_W-1:0] addr);
        ffha_in_t w;
        w.cmd           = CMD_FREE;
        w.request_bytes = 16'($urandom);
        w.block_address = addr;
        return w;
    endfunction

    // Mostly small requests so that the heap holds many blocks and the merge walk
    // stays short; releases favor live blocks, with a few stray addresses as noise.
    function automatic ffha_in_t random_word();
        int pick;
        int free_pct;
        pick     = $urandom_range(0, 99);
        free_pct = (sb.live.size() > 24) ? 65 : 35;
        if (sb.live.size() != 0 && pick < free_pct)
            return free_word(GRANT_W'(sb.live[$urandom_range(0, sb.live.size() - 1)]));
        if (pick >= 92)
            return free_word(GRANT_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 55) return alloc_word(16'($urandom_range(1, 32)));
        if (pick < 80) return alloc_word(16'($urandom_range(33, 256)));
        if (pick < 93) return alloc_word(16'($urandom_range(257, 2048)));
        if (pick < 97) return alloc_word(16'($urandom_range(2049, 8190)));
        return alloc_word(16'($urandom_range(0, 65535)));
    endfunction

    task automatic send_word(input ffha_in_t w);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(1, 100) <= idle_pct) gap = $urandom_range(1, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(w);
    endtask

    // Result side: m_ready drops for short random bursts.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(1, 100) <= idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Reply checking and the watchdog on cycles in which no word moves.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid && m_ready) sb.check_reply(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("first_fit_heap_allocator test failed");
                $finish;
            end
        end
    end

    initial begin
        ffha_in_t directed [$];
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;

        directed.push_back(alloc_word(16'd0));       // zero request fails
        directed.push_back(alloc_word(16'd1));       // payload at word 1
        directed.push_back(alloc_word(16'd2));       // payload at word 3
        directed.push_back(alloc_word(16'd3));       // six-byte block at word 5
        directed.push_back(alloc_word(16'hFFFF));    // rounded size overflows
        directed.push_back(alloc_word(16'hFFFE));
        directed.push_back(alloc_word(16'hFFFD));
        directed.push_back(alloc_word(16'hFFFC));    // fits 16 bits but no run is large enough
        directed.push_back(free_word(12'd0));        // null release
        directed.push_back(free_word(12'd1));
        directed.push_back(free_word(12'd1));        // second release of the same block
        directed.push_back(free_word(12'd2));        // word before is payload, not a header
        directed.push_back(free_word(12'd3));
        directed.push_back(free_word(12'd5));
        directed.push_back(alloc_word(16'd8188));    // merges everything, exact fit of the heap
        directed.push_back(alloc_word(16'd1));       // heap full
        directed.push_back(free_word(12'd1));
        directed.push_back(alloc_word(16'd8190));    // one word too many
        directed.push_back(alloc_word(16'd8187));    // odd request rounds to the whole heap
        directed.push_back(free_word(12'd1));
        directed.push_back(alloc_word(16'd2048));    // cursor at the end marker forces a walk
        directed.push_back(alloc_word(16'd40));      // fast path with a split
        directed.push_back(free_word(12'd4095));     // top address

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) send_word(directed[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            if (i >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            send_word(random_word());
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("first_fit_heap_allocator test passed");
        end else begin
            $display("first_fit_heap_allocator test failed");
        end
        $finish;
    end
endmodule
